@@ rtl/core/tbpl_pkg.sv @@
// ----------------------------------------------------------------------------
// tbpl_pkg
// Types, codes and helpers shared by the tree bitmap lookup engine.
// ----------------------------------------------------------------------------
package tbpl_pkg;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam int ADDR_BITS   = 32;
  localparam int LEN_BITS    = 6;
  localparam int HOPW_BITS   = 8;
  localparam int PFX_BITS    = 15;
  localparam int CHILD_BITS  = 16;
  localparam int NODE_WORD   = PFX_BITS + CHILD_BITS;
  localparam logic [3:0] LEVEL_LAST = 4'd8;
  localparam logic [5:0] LEN_MAX    = 6'd32;

  // One classified command word as it travels from front to back.
  typedef struct packed {
    logic                 is_insert;
    logic [ADDR_BITS-1:0] address;
    logic [3:0]           levels;   // full nibbles to walk on insert
    logic [3:0]           pos_idx;  // internal bitmap bit on insert
    logic [HOPW_BITS-1:0] hop;
  } item_t;

  // Longest internal match of one node; returns {found, bit index}.
  function automatic logic [4:0] best_pos(input logic [PFX_BITS-1:0] pfx,
                                          input logic [3:0] nib,
                                          input logic last_level);
    logic [3:0] i3;
    logic [3:0] i2;
    logic [3:0] i1;
    begin
      i3 = 4'd7 + {1'b0, nib[3:1]};
      i2 = 4'd3 + {2'b00, nib[3:2]};
      i1 = 4'd1 + {3'b000, nib[3]};
      if (last_level) best_pos = pfx[0] ? 5'b1_0000 : 5'b0_0000;
      else if (pfx[i3]) best_pos = {1'b1, i3};
      else if (pfx[i2]) best_pos = {1'b1, i2};
      else if (pfx[i1]) best_pos = {1'b1, i1};
      else if (pfx[0]) best_pos = 5'b1_0000;
      else best_pos = 5'b0_0000;
    end
  endfunction

endpackage

@@ rtl/core/tbpl_ifs.sv @@
// ----------------------------------------------------------------------------
// tbpl stream interfaces
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface tbpl_in_if;
  import tbpl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [ADDR_BITS-1:0] address;
  logic [LEN_BITS-1:0]  prefix_length;
  logic [HOPW_BITS-1:0] hop_in;
  modport source (output valid, command, address, prefix_length, hop_in, input ready);
  modport sink   (input valid, command, address, prefix_length, hop_in, output ready);
endinterface

interface tbpl_out_if;
  import tbpl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [HOPW_BITS-1:0] hop_out;
  logic                 hit;
  logic                 table_full;
  modport source (output valid, hop_out, hit, table_full, input ready);
  modport sink   (input valid, hop_out, hit, table_full, output ready);
endinterface

@@ rtl/core/tbpl_front.sv @@
// ----------------------------------------------------------------------------
// tbpl_front
// Accepts command words and works out prefix placement before queueing.
// ----------------------------------------------------------------------------
module tbpl_front (
  tbpl_in_if.sink          in_ch,
  input  logic             q_full,
  output logic             q_push,
  output tbpl_pkg::item_t  q_item
);
  import tbpl_pkg::*;

  logic [LEN_BITS-1:0] len_sat;
  logic [3:0]          nib;
  logic [1:0]          rest;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    len_sat = (in_ch.prefix_length > LEN_MAX) ? LEN_MAX : in_ch.prefix_length;
    rest    = len_sat[1:0];
    // levels is below eight whenever rest is nonzero
    nib     = 4'(in_ch.address >> (5'd28 - {len_sat[4:2], 2'b00}));
    q_item.is_insert = (in_ch.command == CMD_INSERT);
    q_item.address   = in_ch.address;
    q_item.levels    = len_sat[5:2];
    q_item.hop       = in_ch.hop_in;
    case (rest)
      2'd0:    q_item.pos_idx = 4'd0;
      2'd1:    q_item.pos_idx = 4'd1 + {3'b000, nib[3]};
      2'd2:    q_item.pos_idx = 4'd3 + {2'b00, nib[3:2]};
      default: q_item.pos_idx = 4'd7 + {1'b0, nib[3:1]};
    endcase
  end

endmodule

@@ rtl/core/tbpl_queue.sv @@
// ----------------------------------------------------------------------------
// tbpl_queue
// Two-entry queue between the front and the table engine.
// ----------------------------------------------------------------------------
module tbpl_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tbpl_pkg::item_t  push_item,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output tbpl_pkg::item_t  head
);
  import tbpl_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

@@ rtl/core/tbpl_engine.sv @@
// ----------------------------------------------------------------------------
// tbpl_engine
// Walks the node memories for lookups and inserts, one word at a time.
// ----------------------------------------------------------------------------
module tbpl_engine #(
  parameter int NODE_COUNT = 4096,
  parameter int HOP_BITS   = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  tbpl_pkg::item_t  q_item,
  output logic             q_pop,
  tbpl_out_if.source       out_ch
);
  import tbpl_pkg::*;

  localparam int NW = $clog2(NODE_COUNT);
  localparam logic [NW:0] USED_MAX = (NW+1)'(NODE_COUNT);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NODE  = 3'd1;
  localparam logic [2:0] S_CHILD = 3'd2;
  localparam logic [2:0] S_ALLOC = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // node word: {child bitmap, prefix bitmap}
  logic [NODE_WORD-1:0] node_mem [NODE_COUNT];
  logic [NW-1:0]        slot_mem [NODE_COUNT*16];
  logic [HOP_BITS-1:0]  hop_mem  [NODE_COUNT*16];

  logic [2:0]           state_r, state_nxt;
  item_t                item_r;
  logic [NW-1:0]        node_r, node_nxt;
  logic [3:0]           level_r, level_nxt;
  logic [NW:0]          used_r, used_nxt;
  logic                 root_ok_r, root_ok_nxt;
  logic                 found_r, found_nxt;
  logic                 full_r, full_nxt;
  logic                 hop_pend_r, hop_pend_nxt;
  logic [HOP_BITS-1:0]  hop_r;

  logic [NW-1:0]        rd_addr;
  logic [NODE_WORD-1:0] node_q;
  logic                 rd_zero_r;
  logic [NW-1:0]        slot_q;
  logic [HOP_BITS-1:0]  hop_q;
  logic [NODE_WORD-1:0] word;

  logic                 nw_en;
  logic [NW-1:0]        nw_addr;
  logic [NODE_WORD-1:0] nw_data;
  logic                 sw_en;
  logic                 hw_en;
  logic                 slot_rd;
  logic                 hop_rd;
  logic [3:0]           nib;
  logic [4:0]           bp;
  logic                 last_lvl;
  logic                 child_bit;
  logic [31:0]          hop_in_ext;
  logic [31:0]          hop_out_ext;

  logic                 out_valid_r;
  logic [HOPW_BITS-1:0] out_hop_r;
  logic                 out_hit_r;
  logic                 out_full_r;
  logic                 out_load;

  assign word      = (rd_zero_r && !root_ok_r) ? '0 : node_q;
  assign nib       = 4'(item_r.address >> (5'd28 - {level_r[2:0], 2'b00}));
  assign last_lvl  = (level_r == LEVEL_LAST);
  assign bp        = best_pos(word[PFX_BITS-1:0], nib, last_lvl);
  assign child_bit = !last_lvl && word[PFX_BITS + 32'(nib)];
  assign hop_in_ext  = 32'(item_r.hop);
  // take the hop read still in flight from the last matching node
  assign hop_out_ext = hop_pend_r ? 32'(hop_q) : 32'(hop_r);

  always_comb begin
    state_nxt    = state_r;
    node_nxt     = node_r;
    level_nxt    = level_r;
    used_nxt     = used_r;
    root_ok_nxt  = root_ok_r;
    found_nxt    = found_r;
    full_nxt     = full_r;
    hop_pend_nxt = 1'b0;
    rd_addr      = node_r;
    nw_en        = 1'b0;
    nw_addr      = node_r;
    nw_data      = word;
    sw_en        = 1'b0;
    hw_en        = 1'b0;
    slot_rd      = 1'b0;
    hop_rd       = 1'b0;
    q_pop        = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (q_valid) begin
          q_pop     = 1'b1;
          node_nxt  = '0;
          level_nxt = 4'd0;
          found_nxt = 1'b0;
          full_nxt  = 1'b0;
          state_nxt = S_NODE;
        end
      end
      S_NODE: begin
        if (!item_r.is_insert) begin
          if (bp[4]) begin
            found_nxt    = 1'b1;
            hop_rd       = 1'b1;
            hop_pend_nxt = 1'b1;
          end
          if (child_bit) begin
            slot_rd   = 1'b1;
            state_nxt = S_CHILD;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (level_r == item_r.levels) begin
          // mark the prefix and store its hop
          nw_en     = 1'b1;
          nw_data   = word | (NODE_WORD'(1) << item_r.pos_idx);
          hw_en     = 1'b1;
          state_nxt = S_DONE;
        end else if (child_bit) begin
          slot_rd   = 1'b1;
          state_nxt = S_CHILD;
        end else if (used_r == USED_MAX) begin
          full_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          // link the new child into this node
          nw_en     = 1'b1;
          nw_data   = word | (NODE_WORD'(1) << (PFX_BITS + 32'(nib)));
          sw_en     = 1'b1;
          state_nxt = S_ALLOC;
        end
        if (nw_en && node_r == '0) root_ok_nxt = 1'b1;
      end
      S_CHILD: begin
        rd_addr   = slot_q;
        node_nxt  = slot_q;
        level_nxt = level_r + 4'd1;
        state_nxt = S_NODE;
      end
      S_ALLOC: begin
        nw_en     = 1'b1;
        nw_addr   = used_r[NW-1:0];
        nw_data   = '0;
        node_nxt  = used_r[NW-1:0];
        used_nxt  = used_r + (NW+1)'(1);
        level_nxt = level_r + 4'd1;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_NODE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= (NW+1)'(1);
      root_ok_r   <= 1'b0;
      hop_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      root_ok_r  <= root_ok_nxt;
      hop_pend_r <= hop_pend_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    node_r  <= node_nxt;
    level_r <= level_nxt;
    found_r <= found_nxt;
    full_r  <= full_nxt;
    if (q_pop) item_r <= q_item;
    if (hop_pend_r) hop_r <= hop_q;
    if (out_load) begin
      out_hop_r  <= (item_r.is_insert || !found_r) ? '0 : hop_out_ext[HOPW_BITS-1:0];
      out_hit_r  <= !item_r.is_insert && found_r;
      out_full_r <= item_r.is_insert && full_r;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (nw_en) node_mem[nw_addr] <= nw_data;
    node_q    <= node_mem[rd_addr];
    rd_zero_r <= (rd_addr == '0);
  end

  always_ff @(posedge clk) begin
    if (sw_en) slot_mem[{node_r, nib}] <= used_r[NW-1:0];
    if (slot_rd) slot_q <= slot_mem[{node_r, nib}];
  end

  always_ff @(posedge clk) begin
    if (hw_en) hop_mem[{node_r, item_r.pos_idx}] <= hop_in_ext[HOP_BITS-1:0];
    if (hop_rd) hop_q <= hop_mem[{node_r, bp[3:0]}];
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hop_out    = out_hop_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.table_full = out_full_r;

endmodule

@@ rtl/core/tree_bitmap_prefix_lookup.sv @@
// ----------------------------------------------------------------------------
// tree_bitmap_prefix_lookup
// Stride-4 tree bitmap longest-prefix-match engine with insert.
// ----------------------------------------------------------------------------
// Lookup: each visited level costs the node memory read followed by the child
//   index read at that level.
// Insert: an existing node passes S_NODE, S_CHILD; a new node passes S_NODE, S_ALLOC, S_RD.
// One command at a time in the engine; a two-word queue takes new words meanwhile.
// Reset: synchronous; root node reads as empty until first written, no clearing pass.
module tree_bitmap_prefix_lookup #(
  parameter int NODE_COUNT = 4096,
  parameter int HOP_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  tbpl_in_if.sink     in_ch,
  tbpl_out_if.source  out_ch
);
  import tbpl_pkg::*;

  logic  q_full;
  logic  q_push;
  item_t q_in;
  logic  q_pop;
  logic  q_valid;
  item_t q_head;

  tbpl_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  tbpl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  tbpl_engine #(
    .NODE_COUNT (NODE_COUNT),
    .HOP_BITS   (HOP_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
